>>> hw/rtl/f2d_pkg.sv
// Package for the float32 to 96-bit decimal converter.
// Holds widths, limits, the sequencer state type and the step result type.
package f2d_pkg;
	localparam int MaxScaleDef = 28;
	localparam int ScaleW      = 5;
	localparam int ExpW        = 9;
	localparam int DblMw       = 53;
	localparam int FltMw       = 24;
	localparam int MagW        = 96;
	localparam int NumW        = 26;
	localparam int StopExp     = 21;
	localparam int EfLow       = 34;
	localparam int EfHigh      = 222;
	localparam int ExpBias     = 127;

	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_MUL   = 5'b00010,
		ST_ROUND = 5'b00100,
		ST_STRIP = 5'b01000,
		ST_DONE  = 5'b10000
	} state_t;

	typedef struct packed {
		logic [DblMw-1:0] mant;
		logic [2:0]       einc;
	} step_t;
endpackage

>>> hw/rtl/f2d_mul10.sv
// Shared multiply-by-ten unit on a 53-bit double mantissa, round to nearest even.
// Depends on f2d_pkg.
module f2d_mul10 (
	input  logic [f2d_pkg::DblMw-1:0] mant,
	output f2d_pkg::step_t            res
);
	import f2d_pkg::*;

	logic [DblMw+3:0] prod;
	logic [DblMw-1:0] kept;
	logic             guard;
	logic             sticky;
	logic             up;
	logic [DblMw:0]   sum;
	logic [2:0]       einc;

	always_comb begin
		prod = {1'b0, mant, 3'b000} + {3'b000, mant, 1'b0};
		if (prod[DblMw+3]) begin
			kept   = prod[DblMw+3:4];
			guard  = prod[3];
			sticky = |prod[2:0];
			einc   = 3'd4;
		end else begin
			kept   = prod[DblMw+2:3];
			guard  = prod[2];
			sticky = |prod[1:0];
			einc   = 3'd3;
		end
		up  = guard & (sticky | kept[0]);
		sum = {1'b0, kept} + {{DblMw{1'b0}}, up};
		if (sum[DblMw]) begin
			res.mant = sum[DblMw:1];
			res.einc = einc + 3'd1;
		end else begin
			res.mant = sum[DblMw-1:0];
			res.einc = einc;
		end
	end
endmodule

>>> hw/rtl/float_to_decimal96_convert_core.sv
// Top level of the float32 to 96-bit decimal converter.
// Depends on f2d_pkg and f2d_mul10.
//
// A refused input (zero, infinity, NaN, exponent outside -93..95) goes from acceptance straight
// to loading the output register, with failed set. Any other request is accepted, then takes
// multiply-by-ten steps through the shared f2d_mul10 unit, each after an exit check (up to
// MAX_SCALE steps, none for values already at or above 2^21), is rounded to single precision
// and loads the output register. When the rounded value is an integer with a nonzero scale,
// trailing decimal zeros (at most 7) are stripped one at a time before the load. A result held
// by out_ready low stalls the sequencer before the load, and the input is not ready while a
// request is in progress.
module float_to_decimal96_convert_core #(
	parameter int MAX_SCALE = f2d_pkg::MaxScaleDef
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic [31:0]               float_bits,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic [63:0]               mag_low,
	output logic [31:0]               mag_high,
	output logic                      negative,
	output logic [f2d_pkg::ScaleW-1:0] scale,
	output logic                      failed
);
	import f2d_pkg::*;

	state_t                  state_q;
	logic [DblMw-1:0]        m_q;
	logic signed [ExpW-1:0]  e_q;
	logic [ScaleW-1:0]       scale_q;
	logic                    neg_q;
	logic                    fail_q;
	logic [NumW-1:0]         n_q;
	logic [MagW-1:0]         mag_q;
	logic                    out_valid_q;
	logic [MagW-1:0]         out_mag_q;
	logic                    out_neg_q;
	logic [ScaleW-1:0]       out_scale_q;
	logic                    out_fail_q;

	step_t                   step;
	logic [7:0]              efield;
	logic                    in_fail;
	logic [FltMw:0]          fsum;
	logic [FltMw-1:0]        fmant;
	logic signed [ExpW-1:0]  fexp;
	logic [ExpW-1:0]         rsh;
	logic [ExpW-1:0]         lsh;
	logic [MagW-1:0]         wide;
	logic [FltMw-1:0]        lostmask;
	logic                    is_int;
	logic [NumW+31:0]        qprod;
	logic [NumW-1:0]         q;
	logic [NumW+3:0]         rem;
	logic                    load_out;

	f2d_mul10 u_mul10 (
		.mant (m_q),
		.res  (step)
	);

	always_comb begin
		efield  = float_bits[30:23];
		in_fail = (efield < 8'(EfLow)) || (efield > 8'(EfHigh));

		fsum = {1'b0, m_q[DblMw-1:DblMw-FltMw]}
			+ {{FltMw{1'b0}}, m_q[DblMw-FltMw-1] & ((|m_q[DblMw-FltMw-2:0])
			| m_q[DblMw-FltMw])};
		if (fsum[FltMw]) begin
			fmant = fsum[FltMw:1];
			fexp  = e_q + 9'sd1;
		end else begin
			fmant = fsum[FltMw-1:0];
			fexp  = e_q;
		end
		rsh      = 9'(9'sd23 - fexp);
		lsh      = 9'(fexp - 9'sd23);
		lostmask = (24'd1 << rsh[4:0]) - 24'd1;
		if (fexp < 9'sd0) begin
			wide = '0;
		end else if (fexp <= 9'sd23) begin
			wide = {72'd0, fmant} >> rsh[4:0];
		end else begin
			wide = {72'd0, fmant} << lsh[6:0];
		end
		is_int = !fexp[ExpW-1] && ((fexp > 9'sd23) || ((fmant & lostmask) == '0));

		qprod = n_q * 32'hCCCC_CCCD;
		q     = NumW'(qprod >> 35);
		rem   = {4'd0, n_q} - {1'b0, q, 3'd0} - {3'd0, q, 1'b0};

		load_out = (state_q == ST_DONE) && (!out_valid_q || out_ready);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						state_q <= in_fail ? ST_DONE : ST_MUL;
					end
				end
				ST_MUL: begin
					if (!((scale_q < ScaleW'(MAX_SCALE)) && (e_q < 9'(StopExp)))) begin
						state_q <= ST_ROUND;
					end
				end
				ST_ROUND: begin
					state_q <= ((scale_q != '0) && is_int) ? ST_STRIP : ST_DONE;
				end
				ST_STRIP: begin
					if (!((scale_q != '0) && (rem == '0))) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (load_out) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					fail_q  <= in_fail;
					neg_q   <= float_bits[31] & !in_fail;
					m_q     <= {1'b1, float_bits[22:0], 29'd0};
					e_q     <= $signed({1'b0, efield}) - 9'(ExpBias);
					scale_q <= '0;
					mag_q   <= '0;
				end
			end
			ST_MUL: begin
				if ((scale_q < ScaleW'(MAX_SCALE)) && (e_q < 9'(StopExp))) begin
					m_q     <= step.mant;
					e_q     <= e_q + $signed({6'd0, step.einc});
					scale_q <= scale_q + 5'd1;
				end
			end
			ST_ROUND: begin
				mag_q <= wide;
				n_q   <= wide[NumW-1:0];
			end
			ST_STRIP: begin
				if ((scale_q != '0) && (rem == '0)) begin
					n_q     <= q;
					scale_q <= scale_q - 5'd1;
				end else begin
					mag_q <= {70'd0, n_q};
				end
			end
			ST_DONE: ;
			default: ;
		endcase
		if (load_out) begin
			out_mag_q   <= mag_q;
			out_neg_q   <= neg_q;
			out_scale_q <= scale_q;
			out_fail_q  <= fail_q;
		end
	end

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;
	assign mag_low   = out_mag_q[63:0];
	assign mag_high  = out_mag_q[95:64];
	assign negative  = out_neg_q;
	assign scale     = out_scale_q;
	assign failed    = out_fail_q;
endmodule

>>> hw/rtl/f2d_checker.sv
// Port-level checker for the float32 to 96-bit decimal converter, bound to the top.
// Depends on f2d_pkg and float_to_decimal96_convert_core.
module f2d_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       in_valid,
	input logic                       in_ready,
	input logic                       out_valid,
	input logic                       out_ready,
	input logic [63:0]                mag_low,
	input logic [31:0]                mag_high,
	input logic                       negative,
	input logic [f2d_pkg::ScaleW-1:0] scale,
	input logic                       failed
);
	import f2d_pkg::*;

	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && failed) |-> (mag_low == '0 && mag_high == '0 && scale == '0 && !negative))
		else $error("failed request carries nonzero fields");

	a_scale_max: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (scale <= ScaleW'(MaxScaleDef)))
		else $error("scale above limit");

	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("ready right after accepting a request");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(mag_low) && $stable(scale)))
		else $error("stalled result changed");
endmodule

bind float_to_decimal96_convert_core f2d_checker u_f2d_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.mag_low   (mag_low),
	.mag_high  (mag_high),
	.negative  (negative),
	.scale     (scale),
	.failed    (failed)
);

>>> tb/sv/tb.sv
`timescale 1ns / 100ps
// Self-checking bench for float_to_decimal96_convert_core: directed table plus random floats,
// each result compared to its table entry or to a single/double precision predictor. Depends on f2d_pkg.
module tb;
	import f2d_pkg::*;

	localparam int MAX_SCALE = MaxScaleDef;

	typedef struct {
		logic [63:0]       lo;
		logic [31:0]       hi;
		logic              neg;
		logic [ScaleW-1:0] sc;
		logic              fail;
	} dec_t;

	typedef struct {
		logic [31:0] bits;
		bit          typed;
		dec_t        want;
	} row_t;

	logic              clk;
	logic              arst_n;
	logic              in_valid;
	logic              in_ready;
	logic [31:0]       float_bits;
	logic              out_valid;
	logic              out_ready;
	logic [63:0]       mag_low;
	logic [31:0]       mag_high;
	logic              negative;
	logic [ScaleW-1:0] scale;
	logic              failed;

	dec_t decimal_q[$];
	int   err_cnt = 0;
	int   req_cnt = 0;
	int   fail_cnt = 0;
	int   send_pct = 0;
	int   recv_pct = 0;
	bit   hold_req = 0;
	bit   typed_pending = 0;
	dec_t typed_want;

	float_to_decimal96_convert_core #(.MAX_SCALE(MAX_SCALE)) dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .float_bits(float_bits),
		.out_valid(out_valid), .out_ready(out_ready),
		.mag_low(mag_low), .mag_high(mag_high), .negative(negative),
		.scale(scale), .failed(failed)
	);

	initial clk = 0;
	always begin
		#6 clk = 1;
		#6 clk = 0;
	end

	function automatic bit is_tenfold(real v);
		longint n;
		if (!(v >= 0.0) || v >= 9.0e15)
			return 0;
		n = $rtoi(v);
		if ($itor(n) != v)
			return 0;
		return (n % 10) == 0;
	endfunction

	// round a positive normal double to single precision, nearest even
	function automatic real round_single(real v);
		logic [63:0] db;
		logic [10:0] ex;
		logic [52:0] m;
		logic [24:0] k;
		db = $realtobits(v);
		ex = db[62:52];
		m = {1'b1, db[51:0]};
		k = {1'b0, m[52:29]} + {24'd0, m[28] & ((|m[27:0]) | m[29])};
		if (k[24]) begin
			k = k >> 1;
			ex = ex + 11'd1;
		end
		return $bitstoreal({1'b0, ex, k[22:0], 29'd0});
	endfunction

	function automatic dec_t convert_float(logic [31:0] bits);
		dec_t r;
		int ef, e, sc, s;
		real t;
		logic [63:0] db;
		logic [95:0] mag;
		r = '{lo: '0, hi: '0, neg: 1'b0, sc: '0, fail: 1'b1};
		ef = int'(bits[30:23]);
		e = ef - ExpBias;
		if (bits[30:0] == 0 || ef == 255 || !(e > -94 && e < 96))
			return r;
		db = {1'b0, 11'(e + 1023), bits[22:0], 29'd0};
		t = $bitstoreal(db);
		sc = 0;
		while (sc < MAX_SCALE && t < 2097152.0) begin
			t = t * 10.0;
			sc++;
		end
		t = round_single(t);
		while (sc > 0 && is_tenfold(t)) begin
			sc--;
			t = t / 10.0;
		end
		db = $realtobits(t);
		mag = '0;
		if (db[62:52] != 0) begin
			e = int'(db[62:52]) - 1023;
			if (e >= 0 && e <= 23)
				mag = {72'b0, 1'b1, db[51:29]} >> (23 - e);
			else if (e > 23) begin
				s = e - 23;
				if (s <= 72)
					mag = {72'b0, 1'b1, db[51:29]} << s;
			end
		end
		r.lo = mag[63:0];
		r.hi = mag[95:64];
		r.neg = bits[31];
		r.sc = ScaleW'(sc);
		r.fail = 1'b0;
		return r;
	endfunction

	// record each accepted request
	always @(posedge clk) begin
		if (arst_n && in_valid && in_ready) begin
			decimal_q.push_back(typed_pending ? typed_want : convert_float(float_bits));
			req_cnt++;
		end
	end

	// check each accepted result
	always @(posedge clk) begin
		dec_t w;
		if (arst_n && out_valid && out_ready) begin
			if (decimal_q.size() == 0) begin
				$error("result with no request waiting");
				err_cnt++;
			end else begin
				w = decimal_q.pop_front();
				if (w.fail)
					fail_cnt++;
				if (mag_low !== w.lo) begin
					$error("mag_low: expected %h, got %h", w.lo, mag_low);
					err_cnt++;
				end
				if (mag_high !== w.hi) begin
					$error("mag_high: expected %h, got %h", w.hi, mag_high);
					err_cnt++;
				end
				if (negative !== w.neg) begin
					$error("negative: expected %b, got %b", w.neg, negative);
					err_cnt++;
				end
				if (scale !== w.sc) begin
					$error("scale: expected %0d, got %0d", w.sc, scale);
					err_cnt++;
				end
				if (failed !== w.fail) begin
					$error("failed: expected %b, got %b", w.fail, failed);
					err_cnt++;
				end
			end
		end
	end

	// receiver: random stalls, plus a long hold-off on request
	initial begin
		int hold_left;
		hold_left = 0;
		out_ready = 0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_left = 400;
				hold_req = 0;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 0;
			end else
				out_ready <= ($urandom_range(99) >= recv_pct);
		end
	end

	task automatic send_float(logic [31:0] bits, bit typed, dec_t want);
		while ($urandom_range(99) < send_pct) begin
			in_valid <= 0;
			@(negedge clk);
		end
		in_valid <= 1;
		float_bits <= bits;
		typed_pending = typed;
		typed_want = want;
		do
			@(posedge clk);
		while (!in_ready);
		@(negedge clk);
	endtask

	function automatic logic [31:0] rand_float();
		int pick;
		pick = $urandom_range(99);
		if (pick < 10)
			return $urandom;
		if (pick < 15)
			return {1'($urandom_range(1)), 8'hFF, 23'($urandom)};
		if (pick < 35)
			return {1'($urandom_range(1)), 8'($urandom_range(127 + 21, 127 - 30)),
				23'($urandom)};
		return {1'($urandom_range(1)), 8'($urandom_range(EfHigh, EfLow)), 23'($urandom)};
	endfunction

	initial begin
		dec_t fail_r, none;
		row_t dir_tab[$];
		fail_r = '{lo: '0, hi: '0, neg: 1'b0, sc: '0, fail: 1'b1};
		none = fail_r;
		dir_tab = '{
			'{32'h0000_0000, 1, fail_r},
			'{32'h8000_0000, 1, fail_r},
			'{32'h7F80_0000, 1, fail_r},
			'{32'hFF80_0000, 1, fail_r},
			'{32'h7FC0_0000, 1, fail_r},
			'{32'hFFFF_FFFF, 1, fail_r},
			'{32'h0000_0001, 1, fail_r},
			'{32'h007F_FFFF, 1, fail_r},
			'{32'h0080_0000, 1, fail_r},
			'{32'h1080_0000, 1, fail_r},
			'{32'h6F80_0000, 1, fail_r},
			'{32'h7F7F_FFFF, 1, fail_r},
			'{32'h3F80_0000, 1, '{64'd1, 32'd0, 1'b0, 5'd0, 1'b0}},
			'{32'hBF80_0000, 1, '{64'd1, 32'd0, 1'b1, 5'd0, 1'b0}},
			'{32'h4A00_0000, 1, '{64'd2097152, 32'd0, 1'b0, 5'd0, 1'b0}},
			'{32'h1100_0000, 0, none},
			'{32'h917F_FFFF, 0, none},
			'{32'h6F00_0000, 0, none},
			'{32'hEF7F_FFFF, 0, none},
			'{32'h49FF_FFFF, 0, none},
			'{32'h3DCC_CCCD, 0, none},
			'{32'h4B7F_FFFF, 0, none},
			'{32'h5F00_0000, 0, none},
			'{32'h1234_5678, 0, none},
			'{32'hDEAD_BEEF, 0, none}
		};
		in_valid = 0;
		float_bits = 0;
		arst_n = 0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		send_pct = 19;
		recv_pct = 83;
		foreach (dir_tab[i])
			send_float(dir_tab[i].bits, dir_tab[i].typed, dir_tab[i].want);
		for (int i = 0; i < 150; i++)
			send_float(rand_float(), 0, none);

		// drain fully before switching modes
		in_valid <= 0;
		wait (decimal_q.size() == 0);
		@(negedge clk);
		send_pct = 83;
		recv_pct = 19;
		for (int i = 0; i < 170; i++)
			send_float(rand_float(), 0, none);

		send_pct = 0;
		recv_pct = 0;
		hold_req = 1;
		for (int i = 0; i < 160; i++)
			send_float(rand_float(), 0, none);
		in_valid <= 0;

		wait (decimal_q.size() == 0);
		repeat (100) @(posedge clk);
		$display("Converted %0d requests (%0d refused) across three stall mixes and a long hold-off.",
			req_cnt, fail_cnt);
		if (err_cnt == 0 && decimal_q.size() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

	initial begin
		#20_000_000;
		$display("FAILURE");
		$finish;
	end
endmodule

>>> filelist.f
hw/rtl/f2d_pkg.sv
hw/rtl/f2d_mul10.sv
hw/rtl/float_to_decimal96_convert_core.sv
hw/rtl/f2d_checker.sv
tb/sv/tb.sv
